[rtl/tcoq_pkg.sv]
// shared types and constants of the two-class oldest-first queue
package tcoq_pkg;

  localparam int unsigned StampWidth  = 32;
  localparam int unsigned FuncWidth   = 2;
  localparam int unsigned ClassWidth  = 2;
  localparam int unsigned StatusWidth = 3;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_ENQ     = 2'd0,
    FUNC_DEQ_ANY = 2'd1,
    FUNC_DEQ_C0  = 2'd2,
    FUNC_DEQ_C1  = 2'd3
  } func_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_ENQ   = 3'd0,
    ST_DEQ   = 3'd1,
    ST_EMPTY = 3'd2,
    ST_FULL  = 3'd3,
    ST_DROP  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

[rtl/tcoq_ctrl.sv]
// controller: request sequencing and output register handshake
module tcoq_ctrl import tcoq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // finish only once the output register can take the result
        if (out_free) begin
          cmd_o.execute = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/tcoq_dp.sv]
// datapath: class stores, head and count registers, arrival counter, result register
module tcoq_dp import tcoq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  input  logic [FuncWidth-1:0]     func_i,
  input  logic [ClassWidth-1:0]    item_class_i,
  input  logic [PAYLOAD_WIDTH-1:0] item_payload_i,
  output logic [StatusWidth-1:0]   status_o,
  output logic                     out_class_o,
  output logic [PAYLOAD_WIDTH-1:0] out_payload_o,
  output logic [StampWidth-1:0]    out_stamp_o
);

  localparam int unsigned IdxW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW   = CntW + 1;
  localparam int unsigned EntryW = PAYLOAD_WIDTH + StampWidth;

  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [SumW-1:0] DepthSum = SumW'(QUEUE_DEPTH);

  logic [EntryW-1:0] mem0 [QUEUE_DEPTH];
  logic [EntryW-1:0] mem1 [QUEUE_DEPTH];
  logic [EntryW-1:0] rd0_q, rd1_q;

  func_e                    req_func_q;
  logic [ClassWidth-1:0]    req_class_q;
  logic [PAYLOAD_WIDTH-1:0] req_payload_q;

  logic [IdxW-1:0]       head0_q, head0_d, head1_q, head1_d;
  logic [CntW-1:0]       count0_q, count0_d, count1_q, count1_d;
  logic [StampWidth-1:0] counter_q, counter_d;

  status_e                  status_q, status_d;
  logic                     class_q, class_d;
  logic [PAYLOAD_WIDTH-1:0] payload_q, payload_d;
  logic [StampWidth-1:0]    stamp_q, stamp_d;

  logic [StampWidth-1:0]    stamp_new, rd0_stamp, rd1_stamp, age_diff;
  logic                     take, sel;
  logic [IdxW-1:0]          sel_head, sel_head_next, tail;
  logic [CntW-1:0]          sel_count;
  logic [SumW-1:0]          tail_sum;
  logic [EntryW-1:0]        sel_rd;
  logic                     we0, we1, pop0, pop1, push;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_func_q    <= func_e'(func_i);
      req_class_q   <= item_class_i;
      req_payload_q <= item_payload_i;
    end
  end

  // class stores, read data follows the heads
  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[tail] <= {req_payload_q, stamp_new};
    end
    rd0_q <= mem0[head0_q];
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      mem1[tail] <= {req_payload_q, stamp_new};
    end
    rd1_q <= mem1[head1_q];
  end

  assign stamp_new = counter_q + 1'b1;
  assign rd0_stamp = rd0_q[StampWidth-1:0];
  assign rd1_stamp = rd1_q[StampWidth-1:0];
  assign age_diff  = rd1_stamp - rd0_stamp;

  // class 1 wins only when strictly older, an empty class defers
  always_comb begin
    if (count0_q == '0) begin
      take = 1'b1;
    end else if (count1_q == '0) begin
      take = 1'b0;
    end else begin
      take = age_diff[StampWidth-1];
    end
  end

  always_comb begin
    case (req_func_q)
      FUNC_ENQ:     sel = req_class_q[0];
      FUNC_DEQ_ANY: sel = take;
      FUNC_DEQ_C0:  sel = 1'b0;
      FUNC_DEQ_C1:  sel = 1'b1;
      default:      sel = 1'b0;
    endcase
  end

  assign sel_head  = sel ? head1_q : head0_q;
  assign sel_count = sel ? count1_q : count0_q;
  assign sel_rd    = sel ? rd1_q : rd0_q;

  assign tail_sum      = SumW'(sel_head) + SumW'(sel_count);
  assign tail          = (tail_sum >= DepthSum) ? IdxW'(tail_sum - DepthSum)
                                                : IdxW'(tail_sum);
  assign sel_head_next = (sel_head == LastIdx) ? '0 : sel_head + 1'b1;

  always_comb begin
    counter_d = counter_q;
    status_d  = ST_EMPTY;
    class_d   = sel;
    payload_d = '0;
    stamp_d   = '0;
    push      = 1'b0;
    pop0      = 1'b0;
    pop1      = 1'b0;
    if (req_func_q == FUNC_ENQ) begin
      counter_d = stamp_new;
      stamp_d   = stamp_new;
      if (req_class_q[1]) begin
        status_d = ST_DROP;
        class_d  = 1'b0;
      end else if (sel_count == DepthCnt) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_ENQ;
        push     = 1'b1;
      end
    end else if (sel_count == '0) begin
      // nothing held: "any" reports class 0, a named request its class
      status_d = ST_EMPTY;
      if (req_func_q == FUNC_DEQ_ANY) begin
        class_d = 1'b0;
      end
    end else begin
      status_d  = ST_DEQ;
      payload_d = sel_rd[EntryW-1:StampWidth];
      stamp_d   = sel_rd[StampWidth-1:0];
      pop0      = !sel;
      pop1      = sel;
    end
  end

  assign we0 = cmd_i.execute && push && !sel;
  assign we1 = cmd_i.execute && push && sel;

  always_comb begin
    head0_d  = head0_q;
    head1_d  = head1_q;
    count0_d = count0_q;
    count1_d = count1_q;
    if (we0) count0_d = count0_q + 1'b1;
    if (we1) count1_d = count1_q + 1'b1;
    if (cmd_i.execute && pop0) begin
      head0_d  = sel_head_next;
      count0_d = count0_q - 1'b1;
    end
    if (cmd_i.execute && pop1) begin
      head1_d  = sel_head_next;
      count1_d = count1_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head0_q   <= '0;
      head1_q   <= '0;
      count0_q  <= '0;
      count1_q  <= '0;
      counter_q <= '0;
    end else begin
      head0_q  <= head0_d;
      head1_q  <= head1_d;
      count0_q <= count0_d;
      count1_q <= count1_d;
      if (cmd_i.execute) begin
        counter_q <= counter_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      status_q  <= status_d;
      class_q   <= class_d;
      payload_q <= payload_d;
      stamp_q   <= stamp_d;
    end
  end

  assign status_o      = status_q;
  assign out_class_o   = class_q;
  assign out_payload_o = payload_q;
  assign out_stamp_o   = stamp_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count0_q <= DepthCnt && count1_q <= DepthCnt)
    else $error("class count above depth");

  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && req_func_q == FUNC_ENQ |=> counter_q == $past(counter_q) + 1'b1)
    else $error("arrival counter did not advance on enqueue");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && pop0 |=> count0_q == $past(count0_q) - 1'b1)
    else $error("class 0 count not reduced on dequeue");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we1 |-> count1_q != DepthCnt)
    else $error("write into full class 1 store");
`endif

endmodule

[rtl/two_class_oldest_first_queue_top.sv]
// top level of the two-class oldest-first queue
//
//   channel   signals                                          direction
//   request   in_valid_i/in_ready_o, func_i, item_class_i,      in
//             item_payload_i
//   result    out_valid_o/out_ready_i, status_o, out_class_o,   out
//             out_payload_o, out_stamp_o
//
// each request is first accepted, then executed against the
// registered read of both store heads; one result per request
// execute waits while the output register holds an untaken result
// the next request is accepted while a result waits at the output
// reset clears heads, counts, counter and valids; stores need no clearing
module two_class_oldest_first_queue_top import tcoq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FuncWidth-1:0]     func_i,
  input  logic [ClassWidth-1:0]    item_class_i,
  input  logic [PAYLOAD_WIDTH-1:0] item_payload_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [StatusWidth-1:0]   status_o,
  output logic                     out_class_o,
  output logic [PAYLOAD_WIDTH-1:0] out_payload_o,
  output logic [StampWidth-1:0]    out_stamp_o
);

  ctrl_cmd_t cmd;

  tcoq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tcoq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .item_class_i   (item_class_i),
    .item_payload_i (item_payload_i),
    .status_o       (status_o),
    .out_class_o    (out_class_o),
    .out_payload_o  (out_payload_o),
    .out_stamp_o    (out_stamp_o)
  );

endmodule

[test/tcoq_result_checker.sv]
// result checker for the two-class oldest-first queue: predicts each result and compares it
module tcoq_result_checker import tcoq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [FuncWidth-1:0]     func_i,
  input  logic [ClassWidth-1:0]    item_class_i,
  input  logic [PAYLOAD_WIDTH-1:0] item_payload_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [StatusWidth-1:0]   status_i,
  input  logic                     out_class_i,
  input  logic [PAYLOAD_WIDTH-1:0] out_payload_i,
  input  logic [StampWidth-1:0]    out_stamp_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              results_owed_o
);

  typedef struct {
    status_e                  status;
    logic                     cls;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic [StampWidth-1:0]    stamp;
  } outcome_t;

  logic [PAYLOAD_WIDTH-1:0] held_payload [2][QUEUE_DEPTH];
  logic [StampWidth-1:0]    held_stamp   [2][QUEUE_DEPTH];
  int unsigned              head_idx     [2];
  int unsigned              fill         [2];
  logic [StampWidth-1:0]    arrivals;
  outcome_t                 outcomes_due [$];
  outcome_t                 want;
  outcome_t                 fresh;
  int unsigned              mismatches;

  function automatic outcome_t make_outcome(status_e st, logic cls,
                                            logic [PAYLOAD_WIDTH-1:0] pay,
                                            logic [StampWidth-1:0] stamp);
    outcome_t r;
    r.status  = st;
    r.cls     = cls;
    r.payload = pay;
    r.stamp   = stamp;
    return r;
  endfunction

  function automatic outcome_t pop_class(int unsigned cls);
    int unsigned slot;
    if (fill[cls] == 0) return make_outcome(ST_EMPTY, cls[0], '0, '0);
    slot = head_idx[cls];
    head_idx[cls] = (slot + 1) % QUEUE_DEPTH;
    fill[cls] = fill[cls] - 1;
    return make_outcome(ST_DEQ, cls[0], held_payload[cls][slot], held_stamp[cls][slot]);
  endfunction

  function automatic outcome_t serve_request(func_e f, logic [ClassWidth-1:0] c,
                                             logic [PAYLOAD_WIDTH-1:0] p);
    int unsigned           slot;
    logic [StampWidth-1:0] age_gap;
    outcome_t              r;
    case (f)
      FUNC_ENQ: begin
        // the counter moves even when the item is dropped or refused
        arrivals = arrivals + 1'b1;
        if (c > 1) begin
          r = make_outcome(ST_DROP, 1'b0, '0, arrivals);
        end else if (fill[c] == QUEUE_DEPTH) begin
          r = make_outcome(ST_FULL, c[0], '0, arrivals);
        end else begin
          slot = (head_idx[c] + fill[c]) % QUEUE_DEPTH;
          held_payload[c][slot] = p;
          held_stamp[c][slot]   = arrivals;
          fill[c] = fill[c] + 1;
          r = make_outcome(ST_ENQ, c[0], '0, arrivals);
        end
      end
      FUNC_DEQ_ANY: begin
        if (fill[0] == 0 && fill[1] == 0) begin
          r = make_outcome(ST_EMPTY, 1'b0, '0, '0);
        end else if (fill[0] == 0) begin
          r = pop_class(1);
        end else if (fill[1] == 0) begin
          r = pop_class(0);
        end else begin
          // class 1 only goes first when strictly older, by wrapping distance
          age_gap = held_stamp[1][head_idx[1]] - held_stamp[0][head_idx[0]];
          r = pop_class(age_gap[StampWidth-1] ? 1 : 0);
        end
      end
      FUNC_DEQ_C0: r = pop_class(0);
      default:     r = pop_class(1);
    endcase
    return r;
  endfunction

  task automatic report_field(input string field, input logic [StampWidth-1:0] exp_val,
                              input logic [StampWidth-1:0] act_val);
    mismatches++;
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, exp_val, act_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx = '{0, 0};
      fill     = '{0, 0};
      arrivals = '0;
      outcomes_due.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      results_owed_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (outcomes_due.size() == 0) begin
          mismatches++;
          $display("%0t: unrequested result: expected none, got status %0h stamp %0h",
                   $time, status_i, out_stamp_i);
        end else begin
          want = outcomes_due[0];
          outcomes_due.delete(0);
          if (status_i !== want.status) begin
            report_field("status", StampWidth'(want.status), StampWidth'(status_i));
          end
          if (out_class_i !== want.cls) begin
            report_field("class", StampWidth'(want.cls), StampWidth'(out_class_i));
          end
          if (out_payload_i !== want.payload) begin
            report_field("payload", StampWidth'(want.payload), StampWidth'(out_payload_i));
          end
          if (out_stamp_i !== want.stamp) report_field("stamp", want.stamp, out_stamp_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        fresh = serve_request(func_e'(func_i), item_class_i, item_payload_i);
        outcomes_due = {outcomes_due, fresh};
      end
      mismatch_count_o <= mismatches;
      results_owed_o   <= outcomes_due.size();
    end
  end

endmodule

[test/two_class_oldest_first_queue_top_tb.sv]
// testbench top for the two-class oldest-first queue: clock, reset, stimulus and verdict
module two_class_oldest_first_queue_top_tb;
  import tcoq_pkg::*;

  localparam int unsigned QUEUE_DEPTH   = 16;
  localparam int unsigned PAYLOAD_WIDTH = 16;
  localparam int unsigned RANDOM_ITEMS  = 1000;
  localparam int unsigned IDLE_PERCENT  = 19;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  localparam logic [ClassWidth-1:0] CLASS_FIRST    = 2'd0;
  localparam logic [ClassWidth-1:0] CLASS_SECOND   = 2'd1;
  localparam logic [ClassWidth-1:0] CLASS_UNKNOWN  = 2'd2;
  localparam logic [ClassWidth-1:0] CLASS_UNKNOWN2 = 2'd3;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [FuncWidth-1:0]     func_i;
  logic [ClassWidth-1:0]    item_class_i;
  logic [PAYLOAD_WIDTH-1:0] item_payload_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [StatusWidth-1:0]   status_o;
  logic                     out_class_o;
  logic [PAYLOAD_WIDTH-1:0] out_payload_o;
  logic [StampWidth-1:0]    out_stamp_o;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_wanted;
  bit          hold_served;
  bit          drained_once;

  two_class_oldest_first_queue_top #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .item_class_i  (item_class_i),
    .item_payload_i(item_payload_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_class_o   (out_class_o),
    .out_payload_o (out_payload_o),
    .out_stamp_o   (out_stamp_o)
  );

  tcoq_result_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) results_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .func_i          (func_i),
    .item_class_i    (item_class_i),
    .item_payload_i  (item_payload_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .out_class_i     (out_class_o),
    .out_payload_i   (out_payload_o),
    .out_stamp_i     (out_stamp_o),
    .mismatch_count_o(mismatch_count),
    .results_owed_o  (results_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_wanted && !hold_served) begin
        hold_served = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      out_ready_i <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  task automatic send_request(input func_e f, input logic [ClassWidth-1:0] c,
                              input logic [PAYLOAD_WIDTH-1:0] p);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= f;
    item_class_i   <= c;
    item_payload_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    quiet = (items_sent >= 300) && (items_sent < 500);
  endtask

  task automatic wait_for_results;
    do @(posedge clk_i); while (results_owed != 0);
  endtask

  initial begin
    int unsigned pick;
    int unsigned run;
    logic [ClassWidth-1:0] burst_class;
    items_sent   = 0;
    quiet        = 1'b0;
    hold_wanted  = 1'b0;
    hold_served  = 1'b0;
    drained_once = 1'b0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    func_i         <= FUNC_ENQ;
    item_class_i   <= CLASS_FIRST;
    item_payload_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queues, unknown classes, age order between the classes
    send_request(FUNC_DEQ_ANY, CLASS_FIRST, '0);
    send_request(FUNC_DEQ_C0, CLASS_SECOND, '1);
    send_request(FUNC_DEQ_C1, CLASS_UNKNOWN2, '0);
    send_request(FUNC_ENQ, CLASS_UNKNOWN, 16'h1234);
    send_request(FUNC_ENQ, CLASS_UNKNOWN2, '1);
    send_request(FUNC_ENQ, CLASS_SECOND, '1);
    send_request(FUNC_ENQ, CLASS_FIRST, '0);
    send_request(FUNC_DEQ_ANY, CLASS_FIRST, '0);
    send_request(FUNC_DEQ_ANY, CLASS_FIRST, '0);
    // one past capacity so the last item is refused
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      send_request(FUNC_ENQ, CLASS_FIRST, i[0] ? 16'haaaa : 16'h5555);
    end

    while (items_sent < RANDOM_ITEMS + 26) begin
      if (!hold_wanted && items_sent >= 80) hold_wanted = 1'b1;
      if (!drained_once && items_sent >= 650) begin
        drained_once = 1'b1;
        in_valid_i <= 1'b0;
        wait_for_results();
      end
      pick = $urandom_range(0, 99);
      run  = $urandom_range(1, 20);
      if (pick < 40) begin
        burst_class = ClassWidth'($urandom_range(0, 1));
        repeat (run) begin
          if ($urandom_range(0, 9) < 7) begin
            send_request(FUNC_ENQ, burst_class, PAYLOAD_WIDTH'($urandom));
          end else begin
            send_request(FUNC_ENQ, ClassWidth'($urandom_range(0, 3)),
                         PAYLOAD_WIDTH'($urandom));
          end
        end
      end else if (pick < 70) begin
        repeat (run) begin
          send_request(func_e'($urandom_range(1, 3)), ClassWidth'($urandom_range(0, 3)),
                       PAYLOAD_WIDTH'($urandom));
        end
      end else begin
        send_request(func_e'($urandom_range(0, 3)), ClassWidth'($urandom_range(0, 3)),
                     PAYLOAD_WIDTH'($urandom));
      end
    end

    in_valid_i <= 1'b0;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
